FILE: hw/rtl/gci_pkg.sv
// Shared types and constants for the grid cell index and neighbor block.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package gci_pkg;

    // Fixed field widths
    localparam int POS_W       = 32;
    localparam int CELL_W      = POS_W + 1;
    localparam int VID_W       = 24;
    localparam int IDX_W       = 19;
    localparam int DIM_REG_W   = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    // Operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z    = 3'd6;

    localparam logic [POS_W-1:0] INV_CELL_RESET = 32'h0001_0000;

    // Input word
    typedef struct packed {
        logic                    func;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [VID_W-1:0]        vertex_id;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [IDX_W-1:0] cell_index;
        logic [VID_W-1:0] vertex_out;
        logic             is_insert;
        logic             last;
    } out_word_t;

    // Grid placement registers seen by the front end
    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic signed [POS_W-1:0] origin_z;
        logic [POS_W-1:0]        inv_cell_size;
    } geo_cfg_t;

    // Classified job handed from front to back
    typedef struct packed {
        logic                     func;
        logic [VID_W-1:0]         vid;
        logic signed [CELL_W-1:0] cx;
        logic signed [CELL_W-1:0] cy;
        logic signed [CELL_W-1:0] cz;
    } job_t;

    // Queue status toward both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIFF,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DXY,
        B_TOP,
        B_INS_Y,
        B_INS_Z,
        B_INS_OUT,
        B_Q_CLAMP,
        B_Q_Y,
        B_Q_Z,
        B_WALK
    } back_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gci_front.sv
// Front end: accepts a word, turns the point into signed cell coordinates per axis.
// Uses gci_pkg types; pushes one job per word into gci_queue.
`timescale 1ns / 1ps
`default_nettype none

module gci_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  gci_pkg::in_word_t    item,
    input  gci_pkg::geo_cfg_t    geo,
    input  gci_pkg::queue_stat_t qstat,
    output logic                 busy,
    output logic                 push,
    output gci_pkg::job_t        push_job
);

    gci_pkg::front_state_t state_reg, state_next;
    gci_pkg::axis_t        axis_reg, axis_next;

    gci_pkg::in_word_t item_reg, item_next;
    logic                             neg_reg, neg_next;
    logic [gci_pkg::POS_W-1:0]        mag_reg, mag_next;
    logic signed [gci_pkg::CELL_W-1:0] cx_reg, cx_next;
    logic signed [gci_pkg::CELL_W-1:0] cy_reg, cy_next;
    logic signed [gci_pkg::CELL_W-1:0] cz_reg, cz_next;

    logic signed [gci_pkg::POS_W-1:0]  pos_sel;
    logic signed [gci_pkg::POS_W-1:0]  org_sel;
    logic signed [gci_pkg::CELL_W-1:0] diff;
    logic [2*gci_pkg::POS_W-1:0]       prod;
    logic [gci_pkg::POS_W-1:0]         quot;
    logic signed [gci_pkg::CELL_W-1:0] cell_val;

    // Pick the axis being worked on
    always_comb
    begin
        case (axis_reg)
            gci_pkg::AXIS_X:
            begin
                pos_sel = item_reg.pos_x;
                org_sel = geo.origin_x;
            end
            gci_pkg::AXIS_Y:
            begin
                pos_sel = item_reg.pos_y;
                org_sel = geo.origin_y;
            end
            gci_pkg::AXIS_Z:
            begin
                pos_sel = item_reg.pos_z;
                org_sel = geo.origin_z;
            end
            default:
            begin
                pos_sel = item_reg.pos_x;
                org_sel = geo.origin_x;
            end
        endcase
    end

    // Offset from origin, magnitude and scaled integer part
    assign diff     = $signed({pos_sel[gci_pkg::POS_W-1], pos_sel})
                    - $signed({org_sel[gci_pkg::POS_W-1], org_sel});
    assign prod     = {{gci_pkg::POS_W{1'b0}}, mag_reg}
                    * {{gci_pkg::POS_W{1'b0}}, geo.inv_cell_size};
    assign quot     = prod[2*gci_pkg::POS_W-1:gci_pkg::POS_W];
    assign cell_val = neg_reg ? $signed(gci_pkg::CELL_W'(0) - {1'b0, quot})
                              : $signed({1'b0, quot});

    assign push_job.func = item_reg.func;
    assign push_job.vid  = item_reg.vertex_id;
    assign push_job.cx   = cx_reg;
    assign push_job.cy   = cy_reg;
    assign push_job.cz   = cz_reg;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gci_pkg::F_IDLE;
            axis_reg  <= gci_pkg::AXIS_X;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // Hold the datapath
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
    end

    // Sequence: a difference step and a multiply step per axis, then hand off
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        item_next  = item_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        busy       = (state_reg != gci_pkg::F_IDLE);
        push       = 1'b0;
        case (state_reg)
            gci_pkg::F_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    axis_next  = gci_pkg::AXIS_X;
                    state_next = gci_pkg::F_DIFF;
                end
            end
            gci_pkg::F_DIFF:
            begin
                neg_next   = diff[gci_pkg::CELL_W-1];
                mag_next   = diff[gci_pkg::CELL_W-1] ? gci_pkg::POS_W'(-diff)
                                                     : diff[gci_pkg::POS_W-1:0];
                state_next = gci_pkg::F_MUL;
            end
            gci_pkg::F_MUL:
            begin
                state_next = gci_pkg::F_DIFF;
                case (axis_reg)
                    gci_pkg::AXIS_X:
                    begin
                        cx_next   = cell_val;
                        axis_next = gci_pkg::AXIS_Y;
                    end
                    gci_pkg::AXIS_Y:
                    begin
                        cy_next   = cell_val;
                        axis_next = gci_pkg::AXIS_Z;
                    end
                    default:
                    begin
                        cz_next    = cell_val;
                        axis_next  = gci_pkg::AXIS_X;
                        state_next = gci_pkg::F_PUSH;
                    end
                endcase
            end
            gci_pkg::F_PUSH:
            begin
                if (!qstat.full)
                begin
                    push       = 1'b1;
                    state_next = gci_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = gci_pkg::F_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gci_queue.sv
// Short job queue between the front end and the back end.
// Uses gci_pkg job and status types.
`timescale 1ns / 1ps
`default_nettype none

module gci_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  gci_pkg::job_t        push_job,
    input  wire                  pop,
    output gci_pkg::job_t        pop_job,
    output gci_pkg::queue_stat_t qstat
);

    localparam int QAW = (gci_pkg::QUEUE_DEPTH > 1) ? $clog2(gci_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(gci_pkg::QUEUE_DEPTH + 1);
    localparam logic [QAW-1:0] PTR_LAST = QAW'(gci_pkg::QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] CNT_FULL = QCW'(gci_pkg::QUEUE_DEPTH);

    gci_pkg::job_t  slot_reg [gci_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == CNT_FULL);
    assign qstat.empty = (count_reg == '0);
    assign pop_job     = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gci_back.sv
// Back end: turns a job into a bucket index or walks the 3x3x3 neighbor cells.
// Uses gci_pkg types; pops jobs from gci_queue and drives the result word.
`timescale 1ns / 1ps
`default_nettype none

module gci_back #(
    parameter int MAX_DIM = 64
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire [$clog2(MAX_DIM + 1)-1:0]   dim_x,
    input  wire [$clog2(MAX_DIM + 1)-1:0]   dim_y,
    input  wire [$clog2(MAX_DIM + 1)-1:0]   dim_z,
    input  gci_pkg::queue_stat_t            qstat,
    input  gci_pkg::job_t                   pop_job,
    output logic                            pop,
    output logic                            result_strobe,
    output gci_pkg::out_word_t              result
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int D2W = 2 * DW;
    localparam int D3W = 3 * DW;
    localparam int CW  = gci_pkg::CELL_W;
    localparam int PW  = CW + D2W + 1;
    localparam int SW  = PW + 2;
    localparam int IW  = D3W + 1;

    gci_pkg::back_state_t state_reg, state_next;
    logic strobe_reg, strobe_next;
    gci_pkg::out_word_t result_reg, result_next;

    gci_pkg::job_t        job_reg, job_next;
    logic [D2W-1:0]       dxy_reg, dxy_next;
    logic [D3W-1:0]       top_reg, top_next;
    logic signed [SW-1:0] acc_reg, acc_next;

    logic [DW-1:0]  xx_reg, xx_next;
    logic [DW-1:0]  yy_reg, yy_next;
    logic [DW-1:0]  zz_reg, zz_next;
    logic [DW-1:0]  y0_reg, y0_next;
    logic [DW-1:0]  z0_reg, z0_next;
    logic [DW-1:0]  xe_reg, xe_next;
    logic [DW-1:0]  ye_reg, ye_next;
    logic [DW-1:0]  ze_reg, ze_next;
    logic [D2W-1:0] yterm_reg, yterm_next;
    logic [D2W-1:0] y0term_reg, y0term_next;
    logic [D3W-1:0] zterm_reg, zterm_next;
    logic [D3W-1:0] z0term_reg, z0term_next;

    logic signed [CW-1:0]  mul_a;
    logic [D2W-1:0]        mul_b;
    logic signed [PW-1:0]  prod;
    logic [DW-1:0]         ix, iy, iz;
    logic [IW-1:0]         walk_sum;
    logic                  walk_last;

    // Clamp a signed cell coordinate into 0..d-1
    function automatic logic [DW-1:0] clamp_axis(input logic signed [CW-1:0] c,
                                                 input logic [DW-1:0] d);
        if (c[CW-1])
        begin
            return '0;
        end
        else if (c >= $signed(CW'(d)))
        begin
            return d - DW'(1);
        end
        return DW'(c);
    endfunction

    assign ix = clamp_axis($signed(job_reg.cx), dim_x);
    assign iy = clamp_axis($signed(job_reg.cy), dim_y);
    assign iz = clamp_axis($signed(job_reg.cz), dim_z);

    // Shared multiplier, operands chosen by the step
    always_comb
    begin
        case (state_reg)
            gci_pkg::B_DXY:
            begin
                mul_a = $signed(CW'(dim_x));
                mul_b = D2W'(dim_y);
            end
            gci_pkg::B_TOP:
            begin
                mul_a = $signed(CW'(dim_z));
                mul_b = dxy_reg;
            end
            gci_pkg::B_INS_Y:
            begin
                mul_a = $signed(job_reg.cy);
                mul_b = D2W'(dim_x);
            end
            gci_pkg::B_INS_Z:
            begin
                mul_a = $signed(job_reg.cz);
                mul_b = dxy_reg;
            end
            gci_pkg::B_Q_Y:
            begin
                mul_a = $signed(CW'(y0_reg));
                mul_b = D2W'(dim_x);
            end
            gci_pkg::B_Q_Z:
            begin
                mul_a = $signed(CW'(z0_reg));
                mul_b = dxy_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * $signed({1'b0, mul_b});

    // Current neighbor index and end of walk
    assign walk_sum  = IW'(xx_reg) + IW'(yterm_reg) + IW'(zterm_reg);
    assign walk_last = (xx_reg == xe_reg) && (yy_reg == ye_reg) && (zz_reg == ze_reg);

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gci_pkg::B_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        job_reg    <= job_next;
        dxy_reg    <= dxy_next;
        top_reg    <= top_next;
        acc_reg    <= acc_next;
        xx_reg     <= xx_next;
        yy_reg     <= yy_next;
        zz_reg     <= zz_next;
        y0_reg     <= y0_next;
        z0_reg     <= z0_next;
        xe_reg     <= xe_next;
        ye_reg     <= ye_next;
        ze_reg     <= ze_next;
        yterm_reg  <= yterm_next;
        y0term_reg <= y0term_next;
        zterm_reg  <= zterm_next;
        z0term_reg <= z0term_next;
    end

    // Step through one job
    always_comb
    begin
        state_next  = state_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        job_next    = job_reg;
        dxy_next    = dxy_reg;
        top_next    = top_reg;
        acc_next    = acc_reg;
        xx_next     = xx_reg;
        yy_next     = yy_reg;
        zz_next     = zz_reg;
        y0_next     = y0_reg;
        z0_next     = z0_reg;
        xe_next     = xe_reg;
        ye_next     = ye_reg;
        ze_next     = ze_reg;
        yterm_next  = yterm_reg;
        y0term_next = y0term_reg;
        zterm_next  = zterm_reg;
        z0term_next = z0term_reg;
        pop         = 1'b0;
        case (state_reg)
            gci_pkg::B_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    job_next   = pop_job;
                    state_next = gci_pkg::B_DXY;
                end
            end
            gci_pkg::B_DXY:
            begin
                dxy_next   = D2W'(prod);
                state_next = (job_reg.func == gci_pkg::FUNC_INSERT) ? gci_pkg::B_TOP
                                                                    : gci_pkg::B_Q_CLAMP;
            end
            gci_pkg::B_TOP:
            begin
                top_next   = D3W'(prod);
                state_next = gci_pkg::B_INS_Y;
            end
            gci_pkg::B_INS_Y:
            begin
                acc_next   = SW'($signed(job_reg.cx)) + SW'(prod);
                state_next = gci_pkg::B_INS_Z;
            end
            gci_pkg::B_INS_Z:
            begin
                acc_next   = acc_reg + SW'(prod);
                state_next = gci_pkg::B_INS_OUT;
            end
            gci_pkg::B_INS_OUT:
            begin
                // Clamp the bucket index to 0..cell count
                if (acc_reg[SW-1])
                begin
                    result_next.cell_index = '0;
                end
                else if (acc_reg > $signed(SW'(top_reg)))
                begin
                    result_next.cell_index = gci_pkg::IDX_W'(top_reg);
                end
                else
                begin
                    result_next.cell_index = gci_pkg::IDX_W'(acc_reg);
                end
                result_next.vertex_out = job_reg.vid;
                result_next.is_insert  = 1'b1;
                result_next.last       = 1'b1;
                strobe_next            = 1'b1;
                state_next             = gci_pkg::B_IDLE;
            end
            gci_pkg::B_Q_CLAMP:
            begin
                // Neighborhood bounds that stay inside the grid
                xx_next    = (ix != '0) ? ix - DW'(1) : ix;
                y0_next    = (iy != '0) ? iy - DW'(1) : iy;
                z0_next    = (iz != '0) ? iz - DW'(1) : iz;
                yy_next    = (iy != '0) ? iy - DW'(1) : iy;
                zz_next    = (iz != '0) ? iz - DW'(1) : iz;
                xe_next    = (ix != dim_x - DW'(1)) ? ix + DW'(1) : ix;
                ye_next    = (iy != dim_y - DW'(1)) ? iy + DW'(1) : iy;
                ze_next    = (iz != dim_z - DW'(1)) ? iz + DW'(1) : iz;
                state_next = gci_pkg::B_Q_Y;
            end
            gci_pkg::B_Q_Y:
            begin
                y0term_next = D2W'(prod);
                yterm_next  = D2W'(prod);
                state_next  = gci_pkg::B_Q_Z;
            end
            gci_pkg::B_Q_Z:
            begin
                z0term_next = D3W'(prod);
                zterm_next  = D3W'(prod);
                state_next  = gci_pkg::B_WALK;
            end
            gci_pkg::B_WALK:
            begin
                // Emit one neighbor, z innermost
                result_next.cell_index = gci_pkg::IDX_W'(walk_sum);
                result_next.vertex_out = '0;
                result_next.is_insert  = 1'b0;
                result_next.last       = walk_last;
                strobe_next            = 1'b1;
                if (walk_last)
                begin
                    state_next = gci_pkg::B_IDLE;
                end
                else if (zz_reg != ze_reg)
                begin
                    zz_next    = zz_reg + DW'(1);
                    zterm_next = zterm_reg + D3W'(dxy_reg);
                end
                else
                begin
                    zz_next    = z0_reg;
                    zterm_next = z0term_reg;
                    if (yy_reg != ye_reg)
                    begin
                        yy_next    = yy_reg + DW'(1);
                        yterm_next = yterm_reg + D2W'(dim_x);
                    end
                    else
                    begin
                        yy_next    = y0_reg;
                        yterm_next = y0term_reg;
                        xx_next    = xx_reg + DW'(1);
                    end
                end
            end
            default:
            begin
                state_next = gci_pkg::B_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/grid_cell_index_and_neighbors.sv
// Top level of the grid cell index and neighbor block: configuration registers
// and the front end, queue and back end. Depends on gci_pkg, gci_front, gci_queue, gci_back.
`timescale 1ns / 1ps
`default_nettype none

// A word is taken when start is high and busy is low; busy then stays high while the
// front end works out the three cell coordinates with one 32x32 multiplier (a
// difference step and a multiply step per axis, then a hand-off step), and longer while
// the queue is full, so the front end takes no new word until it has pushed the last
// one. A two-entry queue lets the back end work on earlier words meanwhile. The back
// end steps through its setup states for an insert and then gives one result; for a
// query that has n neighbor cells (n is 1 to 27) it sets up and then walks them, giving
// one result per cycle during the walk. Results appear on result for one cycle each,
// marked by result_strobe; the receiver cannot hold them off, and the last result of
// each word carries last. Write configuration only while idle.
module grid_cell_index_and_neighbors #(
    parameter int MAX_DIM = 64
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    input  gci_pkg::in_word_t                 item,
    output logic                              busy,
    output logic                              result_strobe,
    output gci_pkg::out_word_t                result,
    input  wire                               wr_en,
    input  wire [gci_pkg::CFG_IDX_W-1:0]      wr_index,
    input  wire [gci_pkg::CFG_DATA_W-1:0]     wr_data
);

    localparam int DW = $clog2(MAX_DIM + 1);

    gci_pkg::geo_cfg_t geo_reg;
    logic [gci_pkg::DIM_REG_W-1:0] dim_x_reg, dim_y_reg, dim_z_reg;
    logic [DW-1:0] dim_x_eff, dim_y_eff, dim_z_eff;

    gci_pkg::queue_stat_t qstat;
    gci_pkg::job_t        push_job;
    gci_pkg::job_t        pop_job;
    logic                 push;
    logic                 pop;

    // Zero acts as one, oversize acts as the largest dimension
    function automatic logic [DW-1:0] eff_dim(input logic [gci_pkg::DIM_REG_W-1:0] d);
        if (d == '0)
        begin
            return DW'(1);
        end
        else if (32'(d) > 32'(MAX_DIM))
        begin
            return DW'(MAX_DIM);
        end
        return DW'(d);
    endfunction

    assign dim_x_eff = eff_dim(dim_x_reg);
    assign dim_y_eff = eff_dim(dim_y_reg);
    assign dim_z_eff = eff_dim(dim_z_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geo_reg.origin_x      <= '0;
            geo_reg.origin_y      <= '0;
            geo_reg.origin_z      <= '0;
            geo_reg.inv_cell_size <= gci_pkg::INV_CELL_RESET;
            dim_x_reg             <= gci_pkg::DIM_REG_W'(1);
            dim_y_reg             <= gci_pkg::DIM_REG_W'(1);
            dim_z_reg             <= gci_pkg::DIM_REG_W'(1);
        end
        else if (wr_en)
        begin
            case (wr_index)
                gci_pkg::CFG_ORIGIN_X: geo_reg.origin_x      <= $signed(wr_data);
                gci_pkg::CFG_ORIGIN_Y: geo_reg.origin_y      <= $signed(wr_data);
                gci_pkg::CFG_ORIGIN_Z: geo_reg.origin_z      <= $signed(wr_data);
                gci_pkg::CFG_INV_CELL: geo_reg.inv_cell_size <= wr_data;
                gci_pkg::CFG_DIM_X:    dim_x_reg <= wr_data[gci_pkg::DIM_REG_W-1:0];
                gci_pkg::CFG_DIM_Y:    dim_y_reg <= wr_data[gci_pkg::DIM_REG_W-1:0];
                gci_pkg::CFG_DIM_Z:    dim_z_reg <= wr_data[gci_pkg::DIM_REG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    gci_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .geo      (geo_reg),
        .qstat    (qstat),
        .busy     (busy),
        .push     (push),
        .push_job (push_job)
    );

    gci_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .qstat    (qstat)
    );

    gci_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .dim_x         (dim_x_eff),
        .dim_y         (dim_y_eff),
        .dim_z         (dim_z_eff),
        .qstat         (qstat),
        .pop_job       (pop_job),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/gci_checker.sv
// Port-level checks for grid_cell_index_and_neighbors, attached by bind.
// Depends on gci_pkg for the result word type.
`timescale 1ns / 1ps
`default_nettype none

module gci_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                start,
    input wire                busy,
    input wire                result_strobe,
    input gci_pkg::out_word_t result
);

    // A taken word keeps the front end busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a word was taken");

    // An insert gives exactly one result: each insert result carries last
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.is_insert) |-> result.last)
        else $error("insert result without last");

    // A query result carries no vertex number
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.is_insert) |-> (result.vertex_out == '0))
        else $error("query result with a vertex number");

    // The back end needs setup cycles after finishing a word
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |=> !result_strobe)
        else $error("result right after the last result of a word");

endmodule

bind grid_cell_index_and_neighbors gci_checker u_gci_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .result        (result)
);

`default_nettype wire

FILE: tb/gci_checker.sv
// Checker for the grid cell index and neighbor block: mirrors its registers,
// predicts every result word and compares it with what the block puts out.
// Depends on gci_pkg for the word types, register indexes and operation codes.
`timescale 1ns / 1ps

module gci_scoreboard (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    input  gci_pkg::in_word_t             item,
    input  wire                           busy,
    input  wire                           result_strobe,
    input  gci_pkg::out_word_t            result,
    input  wire                           wr_en,
    input  wire [gci_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire [gci_pkg::CFG_DATA_W-1:0] wr_data,
    output int                            outstanding,
    output int                            errors
);
    import gci_pkg::*;

    localparam int MAX_DIM    = 64;

    // Mirrored grid registers
    logic signed [POS_W-1:0] org_x;
    logic signed [POS_W-1:0] org_y;
    logic signed [POS_W-1:0] org_z;
    logic [POS_W-1:0]        inv_cell;
    logic [DIM_REG_W-1:0]    dim_x;
    logic [DIM_REG_W-1:0]    dim_y;
    logic [DIM_REG_W-1:0]    dim_z;

    // Cell words predicted but not yet seen, oldest first
    out_word_t pending_cells[$];
    int        err_count = 0;

    // A zero count acts as one, an oversized count as the maximum
    function automatic longint dim_eff(input logic [DIM_REG_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return longint'(d);
    endfunction

    // Cell coordinate on one axis: exact Q32.32 product, truncated toward zero
    function automatic longint cell_coord(input logic signed [POS_W-1:0] p,
                                          input logic signed [POS_W-1:0] org);
        longint          diff;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned q;
        diff = longint'(p) - longint'(org);
        mag  = (diff < 0) ? longint'(-diff) : diff;
        prod = mag * 64'(inv_cell);
        q    = prod >> 32;
        return (diff < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Work out the result words of one accepted word
    function automatic void predict_cells(input in_word_t w);
        longint    dx, dy, dz, cx, cy, cz, top, idx, ix, iy, iz;
        longint    xs, xe, ys, ye, zs, ze, a, b, c;
        out_word_t r;
        dx = dim_eff(dim_x);
        dy = dim_eff(dim_y);
        dz = dim_eff(dim_z);
        cx = cell_coord(w.pos_x, org_x);
        cy = cell_coord(w.pos_y, org_y);
        cz = cell_coord(w.pos_z, org_z);
        if (w.func == FUNC_INSERT)
        begin
            // Bucket index, clamped to one past the last cell
            top = dx * dy * dz;
            idx = cx + cy * dx + cz * dx * dy;
            if (idx < 0)
                idx = 0;
            else if (idx > top)
                idx = top;
            r.cell_index = IDX_W'(idx);
            r.vertex_out = w.vertex_id;
            r.is_insert  = 1'b1;
            r.last       = 1'b1;
            pending_cells.insert(pending_cells.size(), r);
        end
        else
        begin
            // Clamp into the grid, then walk the neighbors with z innermost
            ix = (cx < 0) ? 0 : (cx >= dx) ? dx - 1 : cx;
            iy = (cy < 0) ? 0 : (cy >= dy) ? dy - 1 : cy;
            iz = (cz < 0) ? 0 : (cz >= dz) ? dz - 1 : cz;
            xs = (ix <= 0) ? 0 : -1;
            xe = (ix >= dx - 1) ? 0 : 1;
            ys = (iy <= 0) ? 0 : -1;
            ye = (iy >= dy - 1) ? 0 : 1;
            zs = (iz <= 0) ? 0 : -1;
            ze = (iz >= dz - 1) ? 0 : 1;
            for (a = xs; a <= xe; a++)
                for (b = ys; b <= ye; b++)
                    for (c = zs; c <= ze; c++)
                    begin
                        idx = (ix + a) + (iy + b) * dx + (iz + c) * dx * dy;
                        r.cell_index = IDX_W'(idx);
                        r.vertex_out = '0;
                        r.is_insert  = 1'b0;
                        r.last       = (a == xe) && (b == ye) && (c == ze);
                        pending_cells.insert(pending_cells.size(), r);
                    end
        end
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x    = '0;
            org_y    = '0;
            org_z    = '0;
            inv_cell = INV_CELL_RESET;
            dim_x    = 7'd1;
            dim_y    = 7'd1;
            dim_z    = 7'd1;
            pending_cells.delete();
            outstanding <= 0;
            errors      <= 0;
        end
        else
        begin
            // Compare each result word with the oldest prediction
            if (result_strobe)
            begin
                if (pending_cells.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected word: expected none, actual %h",
                             $time, result);
                end
                else
                begin
                    out_word_t want;
                    want = pending_cells.pop_front();
                    check_field("cell_index", 64'(want.cell_index), 64'(result.cell_index));
                    check_field("vertex_out", 64'(want.vertex_out), 64'(result.vertex_out));
                    check_field("is_insert", 64'(want.is_insert), 64'(result.is_insert));
                    check_field("last", 64'(want.last), 64'(result.last));
                end
            end

            // Predict for a word taken at this edge
            if (start && !busy)
                predict_cells(item);

            // Track register writes; unknown indexes are dropped
            if (wr_en)
            begin
                case (wr_index)
                    CFG_ORIGIN_X: org_x    = wr_data;
                    CFG_ORIGIN_Y: org_y    = wr_data;
                    CFG_ORIGIN_Z: org_z    = wr_data;
                    CFG_INV_CELL: inv_cell = wr_data;
                    CFG_DIM_X:    dim_x    = wr_data[DIM_REG_W-1:0];
                    CFG_DIM_Y:    dim_y    = wr_data[DIM_REG_W-1:0];
                    CFG_DIM_Z:    dim_z    = wr_data[DIM_REG_W-1:0];
                    default:      ;
                endcase
            end

            outstanding <= pending_cells.size();
            errors      <= err_count;
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the grid cell index and neighbor block: drives words and
// register writes, then gives the verdict. Depends on gci_pkg, the block and gci_scoreboard.
`timescale 1ns / 1ps

module tb;
    import gci_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int SEGMENTS      = 9;
    localparam int SEG_WORDS     = 40;
    localparam int TAIL_CYCLES   = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    in_word_t           item = '0;
    logic               wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;
    logic               busy;
    logic               result_strobe;
    out_word_t          result;
    int                 outstanding;
    int                 errors;

    // Grid as last written, used to aim points at cells
    logic signed [POS_W-1:0] cur_org [3];
    logic [POS_W-1:0]        cur_inv;
    int                      cur_dim [3];

    grid_cell_index_and_neighbors dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .item          (item),
        .busy          (busy),
        .result_strobe (result_strobe),
        .result        (result),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data)
    );

    gci_scoreboard u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .item          (item),
        .busy          (busy),
        .result_strobe (result_strobe),
        .result        (result),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .outstanding   (outstanding),
        .errors        (errors)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Hold the word until the block takes it
    task automatic send_word(input in_word_t w);
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start for a random number of cycles
    task automatic idle_gap(input int pct);
        if (pct > 0 && $urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < pct);
        end
    endtask

    task automatic issue(input logic func, input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] z, input logic [23:0] vid, input int pct);
        in_word_t w;
        w.func      = func;
        w.pos_x     = x;
        w.pos_y     = y;
        w.pos_z     = z;
        w.vertex_id = vid;
        send_word(w);
        idle_gap(pct);
    endtask

    // Wait until every predicted word has come out
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0 || busy);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
    endtask

    // Reprogram the whole grid while the block is idle
    task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] oz, input logic [31:0] inv,
                            input logic [6:0] dx, input logic [6:0] dy,
                            input logic [6:0] dz);
        logic [6:0] dims [3];
        drain();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_INV_CELL, inv);
        write_reg(CFG_DIM_X, {25'($urandom), dx});
        write_reg(CFG_DIM_Y, {25'($urandom), dy});
        write_reg(CFG_DIM_Z, {25'($urandom), dz});
        write_reg(CFG_UNUSED, $urandom);
        wr_en <= 1'b0;
        cur_org[0] = ox;
        cur_org[1] = oy;
        cur_org[2] = oz;
        cur_inv    = inv;
        dims[0] = dx;
        dims[1] = dy;
        dims[2] = dz;
        for (int i = 0; i < 3; i++)
            cur_dim[i] = (dims[i] == 0) ? 1 : (dims[i] > 64) ? 64 : int'(dims[i]);
    endtask

    function automatic logic [31:0] pick_origin();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6)
            return 32'($urandom_range(0, 2 * 1048576)) - 32'd1048576;
        if (kind < 8)
            return $urandom;
        case ($urandom_range(0, 2))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [6:0] pick_dim();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 3)
            return 7'($urandom_range(1, 3));
        if (kind < 8)
            return 7'($urandom_range(1, 64));
        if (kind < 9)
            return 7'd0;
        return 7'($urandom_range(65, 127));
    endfunction

    function automatic logic [31:0] pick_inv();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7)
            return 32'($urandom_range(1 << 12, 1 << 22));
        if (kind < 8)
            return 32'd0;
        if (kind < 9)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Coordinate that lands in or next to cell t on one axis
    function automatic logic [31:0] aim(input int axis, input int t);
        longint unsigned span;
        longint          d;
        if (cur_inv == 0)
            return $urandom;
        span = (longint'((t < 0) ? -t : t) << 32) + 64'($urandom);
        d    = longint'(span / 64'(cur_inv));
        if (t < 0)
            d = -d;
        return 32'(longint'(cur_org[axis]) + d);
    endfunction

    function automatic logic [31:0] pick_coord(input int axis, input int kind);
        if (kind < 70)
            return aim(axis, int'($urandom_range(0, cur_dim[axis] + 3)) - 2);
        if (kind < 85)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return cur_org[axis];
        endcase
    endfunction

    initial
    begin
        int kind;
        int pct;
        cur_org[0] = '0;
        cur_org[1] = '0;
        cur_org[2] = '0;
        cur_inv    = INV_CELL_RESET;
        cur_dim[0] = 1;
        cur_dim[1] = 1;
        cur_dim[2] = 1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset grid: a single cell
        issue(FUNC_INSERT, 32'h0, 32'h0, 32'h0, 24'hFF_FFFF, 27);
        issue(FUNC_QUERY, 32'h0, 32'h0, 32'h0, 24'h00_0000, 27);
        issue(FUNC_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'h12_3456, 0);
        issue(FUNC_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h00_0000, 0);

        // Unit cells in a 4x4x4 grid: corners, center, outside, truncation
        set_grid(32'h0, 32'h0, 32'h0, 32'h0001_0000, 7'd4, 7'd4, 7'd4);
        issue(FUNC_QUERY, 32'h0, 32'h0, 32'h0, 24'h0, 27);
        issue(FUNC_QUERY, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000, 24'h0, 0);
        issue(FUNC_QUERY, 32'h0003_8000, 32'h0003_8000, 32'h0003_8000, 24'h0, 27);
        issue(FUNC_QUERY, 32'h000A_0000, 32'hFFF6_0000, 32'h0002_8000, 24'h0, 0);
        issue(FUNC_INSERT, 32'h0002_8000, 32'h0001_8000, 32'h0003_8000, 24'hAB_CDEF, 27);
        issue(FUNC_INSERT, 32'hFFFF_8000, 32'h0, 32'h0, 24'h00_0001, 0);
        issue(FUNC_INSERT, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000, 24'h80_0000, 27);
        issue(FUNC_INSERT, 32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 24'h7F_FFFF, 0);

        // Widest grid and largest reciprocal: top bucket and far corner
        set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                 7'd64, 7'd64, 7'd64);
        issue(FUNC_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h55_AAAA, 0);
        issue(FUNC_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 27);
        issue(FUNC_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h0, 0);
        issue(FUNC_INSERT, 32'h8000_0002, 32'h8000_0001, 32'h8000_0003, 24'h00_0F0F, 27);

        // Zero reciprocal, zero dimension and oversized dimensions
        set_grid(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 7'd0, 7'd127, 7'd65);
        issue(FUNC_QUERY, 32'h0, 32'h0, 32'h0, 24'h0, 0);
        issue(FUNC_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 24'h33_3333, 27);
        issue(FUNC_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 24'h0, 0);

        // Cells of edge two, a flat slab one cell deep in y
        set_grid(32'hFFFD_0000, 32'h0002_0000, 32'h0, 32'h0000_8000, 7'd5, 7'd1, 7'd3);
        issue(FUNC_QUERY, 32'h0000_0000, 32'h0002_0000, 32'h0002_8000, 24'h0, 27);
        issue(FUNC_QUERY, 32'hFFFC_0000, 32'h0010_0000, 32'h0006_0000, 24'h0, 0);
        issue(FUNC_INSERT, 32'h0003_0000, 32'h0002_8000, 32'h0004_0000, 24'hC0_FFEE, 0);

        // Random grids; sender idles 27%, then 80%, then not at all
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            pct = (seg < 3) ? 27 : (seg < 6) ? 80 : 0;
            set_grid(pick_origin(), pick_origin(), pick_origin(), pick_inv(),
                     pick_dim(), pick_dim(), pick_dim());
            for (int n = 0; n < SEG_WORDS; n++)
            begin
                kind = $urandom_range(0, 99);
                issue(1'($urandom_range(0, 1)), pick_coord(0, kind), pick_coord(1, kind),
                      pick_coord(2, kind), 24'($urandom), pct);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
